FILE: hw/rtl/uer_pkg.sv
// ---------------------------------------------------------------------------
// uer_pkg
// Shared types and constants of the ultrasonic echo ranger.
// ---------------------------------------------------------------------------
package uer_pkg;

    localparam int SAMPLES   = 3;
    localparam int CNT_W     = 17;
    localparam int SUM_W     = 18;
    localparam int DIV_W     = SUM_W;
    localparam int DVS_W     = 8;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALID  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLIND      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_US_PER_CM  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PING_GAP   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_OBSTACLE   = 3'd7;

    localparam logic [1:0] ST_VALID   = 2'd0;
    localparam logic [1:0] ST_BLIND   = 2'd1;
    localparam logic [1:0] ST_NO_ECHO = 2'd2;

    localparam logic [7:0]  RST_TRIG_LOW  = 8'd5;
    localparam logic [7:0]  RST_TRIG_HIGH = 8'd10;
    localparam logic [15:0] RST_TIMEOUT   = 16'd38000;
    localparam logic [15:0] RST_MAX_VALID = 16'd23200;
    localparam logic [15:0] RST_BLIND     = 16'd116;
    localparam logic [7:0]  RST_US_PER_CM = 8'd58;
    localparam logic [15:0] RST_PING_GAP  = 16'd15000;
    localparam logic [15:0] RST_OBSTACLE  = 16'd20;

    typedef struct packed {
        logic [7:0]  trig_low_us;
        logic [7:0]  trig_high_us;
        logic [15:0] echo_timeout_us;
        logic [15:0] max_valid_us;
        logic [15:0] blind_us;
        logic [7:0]  us_per_cm;
        logic [15:0] ping_gap_us;
        logic [15:0] obstacle_cm;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic        trig;
        logic        busy_res;
        logic        done_res;
        logic [15:0] distance_cm;
        logic [1:0]  status;
        logic        obstacle;
    } t_res;

endpackage

FILE: hw/rtl/uer_if.sv
// ---------------------------------------------------------------------------
// uer_if
// Valid/ready channels of the echo ranger: tick input, result and config.
// ---------------------------------------------------------------------------
interface uer_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic echo;

    modport source (output valid, output start_req, output echo, input ready);
    modport sink   (input valid, input start_req, input echo, output ready);
endinterface

interface uer_out_if;
    logic        valid;
    logic        ready;
    logic        trig;
    logic        busy_res;
    logic        done_res;
    logic [15:0] distance_cm;
    logic [1:0]  status;
    logic        obstacle;

    modport source (output valid, output trig, output busy_res, output done_res,
                    output distance_cm, output status, output obstacle, input ready);
    modport sink   (input valid, input trig, input busy_res, input done_res,
                    input distance_cm, input status, input obstacle, output ready);
endinterface

interface uer_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/uer_regs.sv
// ---------------------------------------------------------------------------
// uer_regs
// Configuration register file, written one register per beat.
// ---------------------------------------------------------------------------
module uer_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    uer_cfg_if.sink       i_cfg,
    output uer_pkg::t_cfg o_cfg
);
    import uer_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_TRIG_LOW:  n_cfg.trig_low_us     = i_cfg.data[7:0];
                CFG_TRIG_HIGH: n_cfg.trig_high_us    = i_cfg.data[7:0];
                CFG_TIMEOUT:   n_cfg.echo_timeout_us = i_cfg.data;
                CFG_MAX_VALID: n_cfg.max_valid_us    = i_cfg.data;
                CFG_BLIND:     n_cfg.blind_us        = i_cfg.data;
                CFG_US_PER_CM: n_cfg.us_per_cm       = i_cfg.data[7:0];
                CFG_PING_GAP:  n_cfg.ping_gap_us     = i_cfg.data;
                CFG_OBSTACLE:  n_cfg.obstacle_cm     = i_cfg.data;
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trig_low_us     <= RST_TRIG_LOW;
            r_cfg.trig_high_us    <= RST_TRIG_HIGH;
            r_cfg.echo_timeout_us <= RST_TIMEOUT;
            r_cfg.max_valid_us    <= RST_MAX_VALID;
            r_cfg.blind_us        <= RST_BLIND;
            r_cfg.us_per_cm       <= RST_US_PER_CM;
            r_cfg.ping_gap_us     <= RST_PING_GAP;
            r_cfg.obstacle_cm     <= RST_OBSTACLE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: hw/rtl/uer_div.sv
// ---------------------------------------------------------------------------
// uer_div
// Shared restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module uer_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  uer_pkg::t_div_req i_req,
    output uer_pkg::t_div_rsp o_rsp
);
    import uer_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0]     r_rem;
    logic [DVS_W-1:0]     r_dvs;
    logic [DIV_W-1:0]     r_quot;

    logic [DVS_W:0]       w_try;
    logic [DVS_W:0]       w_diff;
    logic                 w_ge;

    assign w_try  = {r_rem, r_quot[DIV_W-1]};
    assign w_ge   = w_try >= {1'b0, r_dvs};
    assign w_diff = w_try - {1'b0, r_dvs};

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_W - 1);
                r_rem  <= '0;
                r_quot <= i_req.dividend;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_diff[DVS_W-1:0] : w_try[DVS_W-1:0];
                r_quot <= {r_quot[DIV_W-2:0], w_ge};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

endmodule

FILE: hw/rtl/ultrasonic_echo_ranger_unit.sv
// ---------------------------------------------------------------------------
// ultrasonic_echo_ranger_unit
// Ultrasonic time-of-flight ranger driven by one input beat per microsecond.
// ---------------------------------------------------------------------------
// An ordinary tick beat yields its result beat in the cycle after acceptance,
// and such beats can be accepted back to back while the output is not stalled.
// A finishing tick with valid echoes holds the input during two passes of the
// shared divider, average then centimeters.
// Blind zone or a zero divisor skips the second pass.
// Synchronous active-low reset restores register defaults, idles the ranger and
// empties the output register.
// ---------------------------------------------------------------------------
module ultrasonic_echo_ranger_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    uer_in_if.sink    i_in,
    uer_out_if.source o_out,
    uer_cfg_if.sink   i_cfg
);
    import uer_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE, PH_TLO, PH_THI, PH_WAIT, PH_MEAS, PH_GAP
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE, S_DIV_AVG, S_DIV_CM, S_PUT
    } t_seq;

    t_cfg     w_cfg;
    t_div_req w_req;
    t_div_rsp w_rsp;

    t_phase           r_phase, n_phase, w_phase;
    logic [CNT_W-1:0] r_cnt, n_cnt, w_cnt;
    logic [1:0]       r_pidx, n_pidx, w_pidx;
    logic [1:0]       r_vcnt, n_vcnt, w_vcnt;
    logic [SUM_W-1:0] r_wsum, n_wsum, w_wsum;
    logic             w_trig;
    logic             w_fin;

    t_seq  r_seq, n_seq;
    logic  r_out_valid, n_out_valid;
    t_res  r_out, n_out;
    t_res  r_res, n_res;
    logic  w_ready;
    logic  w_accept;

    uer_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    uer_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_ready    = (r_seq == S_IDLE) && (!r_out_valid || o_out.ready);
    assign w_accept   = i_in.valid && w_ready;
    assign i_in.ready = w_ready;

    assign o_out.valid       = r_out_valid;
    assign o_out.trig        = r_out.trig;
    assign o_out.busy_res    = r_out.busy_res;
    assign o_out.done_res    = r_out.done_res;
    assign o_out.distance_cm = r_out.distance_cm;
    assign o_out.status      = r_out.status;
    assign o_out.obstacle    = r_out.obstacle;

    // Per-tick phase update.
    always_comb begin
        logic             do_end;
        logic             do_after;
        logic [CNT_W-1:0] end_w;

        w_phase  = r_phase;
        w_cnt    = r_cnt;
        w_pidx   = r_pidx;
        w_vcnt   = r_vcnt;
        w_wsum   = r_wsum;
        w_trig   = 1'b0;
        w_fin    = 1'b0;
        do_end   = 1'b0;
        do_after = 1'b0;
        end_w    = '0;

        if (r_phase == PH_IDLE && i_in.start_req) begin
            w_pidx = '0;
            w_vcnt = '0;
            w_wsum = '0;
            w_cnt  = '0;
            if (w_cfg.trig_low_us != '0) begin
                w_phase = PH_TLO;
            end else if (w_cfg.trig_high_us != '0) begin
                w_phase = PH_THI;
            end else begin
                w_phase = PH_WAIT;
            end
        end

        case (w_phase)
            PH_TLO: begin
                w_cnt = w_cnt + 1'b1;
                if (w_cnt >= CNT_W'(w_cfg.trig_low_us)) begin
                    w_cnt   = '0;
                    w_phase = (w_cfg.trig_high_us == '0) ? PH_WAIT : PH_THI;
                end
            end
            PH_THI: begin
                w_trig = 1'b1;
                w_cnt  = w_cnt + 1'b1;
                if (w_cnt >= CNT_W'(w_cfg.trig_high_us)) begin
                    w_cnt   = '0;
                    w_phase = PH_WAIT;
                end
            end
            PH_WAIT: begin
                if (i_in.echo) begin
                    w_phase = PH_MEAS;
                    w_cnt   = CNT_W'(1);
                end else begin
                    w_cnt = w_cnt + 1'b1;
                end
                if (w_cnt > CNT_W'(w_cfg.echo_timeout_us)) begin
                    do_end = 1'b1;
                end
            end
            PH_MEAS: begin
                if (i_in.echo) begin
                    w_cnt = w_cnt + 1'b1;
                    if (w_cnt > CNT_W'(w_cfg.echo_timeout_us)) begin
                        do_end = 1'b1;
                    end
                end else begin
                    do_end = 1'b1;
                    end_w  = w_cnt;
                end
            end
            PH_GAP: begin
                w_cnt = w_cnt + 1'b1;
                if (w_cnt >= CNT_W'(w_cfg.ping_gap_us)) begin
                    do_after = 1'b1;
                end
            end
            default: begin
                w_phase = PH_IDLE;
                w_cnt   = '0;
            end
        endcase

        if (do_end) begin
            if (end_w != '0 && end_w <= CNT_W'(w_cfg.max_valid_us)) begin
                w_wsum = w_wsum + SUM_W'(end_w);
                w_vcnt = w_vcnt + 1'b1;
            end
            w_cnt = '0;
            if (w_cfg.ping_gap_us == '0) begin
                do_after = 1'b1;
            end else begin
                w_phase = PH_GAP;
            end
        end

        if (do_after) begin
            w_pidx = w_pidx + 1'b1;
            w_cnt  = '0;
            if (w_pidx >= 2'(SAMPLES)) begin
                w_fin   = 1'b1;
                w_phase = PH_IDLE;
            end else if (w_cfg.trig_low_us != '0) begin
                w_phase = PH_TLO;
            end else if (w_cfg.trig_high_us != '0) begin
                w_phase = PH_THI;
            end else begin
                w_phase = PH_WAIT;
            end
        end
    end

    // Result sequencer around the shared divider.
    always_comb begin
        logic [15:0] dist_cm;

        n_phase     = w_accept ? w_phase : r_phase;
        n_cnt       = w_accept ? w_cnt   : r_cnt;
        n_pidx      = w_accept ? w_pidx  : r_pidx;
        n_vcnt      = w_accept ? w_vcnt  : r_vcnt;
        n_wsum      = w_accept ? w_wsum  : r_wsum;
        n_seq       = r_seq;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out       = r_out;
        n_res       = r_res;
        dist_cm     = '0;

        w_req.start    = 1'b0;
        w_req.dividend = w_wsum;
        w_req.divisor  = {{(DVS_W-2){1'b0}}, w_vcnt};

        case (r_seq)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_fin && w_vcnt != '0) begin
                        w_req.start = 1'b1;
                        n_seq       = S_DIV_AVG;
                    end else begin
                        n_out_valid       = 1'b1;
                        n_out.trig        = w_trig;
                        n_out.busy_res    = (w_phase != PH_IDLE);
                        n_out.done_res    = w_fin;
                        n_out.distance_cm = '0;
                        n_out.status      = w_fin ? ST_NO_ECHO : ST_VALID;
                        n_out.obstacle    = 1'b0;
                    end
                end
            end
            S_DIV_AVG: begin
                if (w_rsp.done) begin
                    n_res.trig     = 1'b0;
                    n_res.busy_res = 1'b0;
                    n_res.done_res = 1'b1;
                    if (w_rsp.quot < SUM_W'(w_cfg.blind_us)) begin
                        n_res.distance_cm = '0;
                        n_res.status      = ST_BLIND;
                        n_res.obstacle    = 1'b1;
                        n_seq             = S_PUT;
                    end else if (w_cfg.us_per_cm == '0) begin
                        n_res.distance_cm = 16'hFFFF;
                        n_res.status      = ST_VALID;
                        n_res.obstacle    = 16'hFFFF < w_cfg.obstacle_cm;
                        n_seq             = S_PUT;
                    end else begin
                        w_req.start    = 1'b1;
                        w_req.dividend = w_rsp.quot;
                        w_req.divisor  = w_cfg.us_per_cm;
                        n_seq          = S_DIV_CM;
                    end
                end
            end
            S_DIV_CM: begin
                if (w_rsp.done) begin
                    dist_cm = (w_rsp.quot[DIV_W-1:16] != '0) ? 16'hFFFF : w_rsp.quot[15:0];
                    n_res.distance_cm = dist_cm;
                    n_res.status      = ST_VALID;
                    n_res.obstacle    = dist_cm < w_cfg.obstacle_cm;
                    n_seq             = S_PUT;
                end
            end
            S_PUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_seq       = S_IDLE;
                end
            end
            default: n_seq = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_cnt       <= '0;
            r_pidx      <= '0;
            r_vcnt      <= '0;
            r_wsum      <= '0;
            r_seq       <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_pidx      <= n_pidx;
            r_vcnt      <= n_vcnt;
            r_wsum      <= n_wsum;
            r_seq       <= n_seq;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
        r_res <= n_res;
    end

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> !w_rsp.busy)
        else $error("divider started while busy");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> !r_out.busy_res)
        else $error("result beat marked done and busy");

    a_status_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_VALID) |-> (r_out.distance_cm == '0))
        else $error("nonzero distance with non-valid status");

    a_no_accept_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == S_DIV_AVG || r_seq == S_DIV_CM) |-> (r_phase == PH_IDLE))
        else $error("division running while a measurement is active");

endmodule
